[hw/rtl/dtbs_pkg.sv]
package dtbs_pkg;

  localparam int unsigned CfgWidth   = 16;
  localparam int unsigned IndexWidth = 3;
  localparam int unsigned StepWidth  = 3;

  // Register indexes of the configuration port
  localparam logic [IndexWidth-1:0] REG_DEBOUNCE    = 3'd0;
  localparam logic [IndexWidth-1:0] REG_SHORT_BEEP  = 3'd1;
  localparam logic [IndexWidth-1:0] REG_LONG_BEEP   = 3'd2;
  localparam logic [IndexWidth-1:0] REG_BEEP_GAP    = 3'd3;
  localparam logic [IndexWidth-1:0] REG_PATTERN_GAP = 3'd4;
  localparam logic [IndexWidth-1:0] REG_COOLDOWN    = 3'd5;

  // Pattern phases
  localparam logic [StepWidth-1:0] STEP_BEEP_1     = 3'd0;
  localparam logic [StepWidth-1:0] STEP_GAP_1      = 3'd1;
  localparam logic [StepWidth-1:0] STEP_BEEP_2     = 3'd2;
  localparam logic [StepWidth-1:0] STEP_GAP_2      = 3'd3;
  localparam logic [StepWidth-1:0] STEP_BEEP_3     = 3'd4;
  localparam logic [StepWidth-1:0] STEP_PATTERN_GAP = 3'd5;
  localparam logic [StepWidth-1:0] STEP_LONG_BEEP  = 3'd6;

  // Reset values of the registers
  localparam logic [CfgWidth-1:0] RST_DEBOUNCE    = 16'd50;
  localparam logic [CfgWidth-1:0] RST_SHORT_BEEP  = 16'd150;
  localparam logic [CfgWidth-1:0] RST_LONG_BEEP   = 16'd800;
  localparam logic [CfgWidth-1:0] RST_BEEP_GAP    = 16'd100;
  localparam logic [CfgWidth-1:0] RST_PATTERN_GAP = 16'd200;
  localparam logic [CfgWidth-1:0] RST_COOLDOWN    = 16'd1000;

  typedef struct packed {
    logic [CfgWidth-1:0] debounce_ms;
    logic [CfgWidth-1:0] short_beep_ms;
    logic [CfgWidth-1:0] long_beep_ms;
    logic [CfgWidth-1:0] beep_gap_ms;
    logic [CfgWidth-1:0] pattern_gap_ms;
    logic [CfgWidth-1:0] cooldown_ms;
  } cfg_t;

  typedef struct packed {
    logic                 relay_on;
    logic [StepWidth-1:0] pattern_step;
    logic                 sequence_active;
    logic                 cooling_down;
  } result_t;

endpackage

[hw/rtl/dtbs_cfg_regs.sv]
module dtbs_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [dtbs_pkg::IndexWidth-1:0]   cfg_index,
  input  logic [dtbs_pkg::CfgWidth-1:0]     cfg_data,
  output dtbs_pkg::cfg_t                    cfg
);
  import dtbs_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms    <= RST_DEBOUNCE;
      cfg.short_beep_ms  <= RST_SHORT_BEEP;
      cfg.long_beep_ms   <= RST_LONG_BEEP;
      cfg.beep_gap_ms    <= RST_BEEP_GAP;
      cfg.pattern_gap_ms <= RST_PATTERN_GAP;
      cfg.cooldown_ms    <= RST_COOLDOWN;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DEBOUNCE:    cfg.debounce_ms    <= cfg_data;
        REG_SHORT_BEEP:  cfg.short_beep_ms  <= cfg_data;
        REG_LONG_BEEP:   cfg.long_beep_ms   <= cfg_data;
        REG_BEEP_GAP:    cfg.beep_gap_ms    <= cfg_data;
        REG_PATTERN_GAP: cfg.pattern_gap_ms <= cfg_data;
        REG_COOLDOWN:    cfg.cooldown_ms    <= cfg_data;
        default: ; // drop writes to unknown indexes
      endcase
    end
  end

endmodule

[hw/rtl/dtbs_debounce.sv]
module dtbs_debounce #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           tick,
  input  logic           raw,
  input  dtbs_pkg::cfg_t cfg,
  output logic           press
);
  import dtbs_pkg::*;

  localparam int unsigned CmpWidth = (TIMER_WIDTH > CfgWidth) ? TIMER_WIDTH : CfgWidth;

  logic                   previous_raw;
  logic                   stable_level;
  logic [TIMER_WIDTH-1:0] debounce_count;
  logic [TIMER_WIDTH-1:0] debounce_count_next;
  logic                   settle;

  always_comb begin
    if (raw != previous_raw) begin
      debounce_count_next = '0;
    end else if (debounce_count == '1) begin
      debounce_count_next = debounce_count;
    end else begin
      debounce_count_next = debounce_count + TIMER_WIDTH'(1);
    end
    settle = (CmpWidth'(debounce_count_next) > CmpWidth'(cfg.debounce_ms))
             && (raw != stable_level);
  end

  // A settled fall to pressed (level 0) is the trigger
  assign press = settle && !raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_raw   <= 1'b1;
      stable_level   <= 1'b1;
      debounce_count <= '0;
    end else if (tick) begin
      previous_raw   <= raw;
      debounce_count <= debounce_count_next;
      if (settle) begin
        stable_level <= raw;
      end
    end
  end

endmodule

[hw/rtl/dtbs_pattern.sv]
module dtbs_pattern #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              tick,
  input  logic              press,
  input  dtbs_pkg::cfg_t    cfg,
  output dtbs_pkg::result_t result_next
);
  import dtbs_pkg::*;

  localparam int unsigned CmpWidth = (TIMER_WIDTH > CfgWidth) ? TIMER_WIDTH : CfgWidth;

  logic                   running;
  logic                   cooling;
  logic                   relay_drive;
  logic [StepWidth-1:0]   step_index;
  logic [TIMER_WIDTH-1:0] step_elapsed;
  logic [TIMER_WIDTH-1:0] cooldown_count;

  logic                   running_next;
  logic                   cooling_next;
  logic                   relay_drive_next;
  logic [StepWidth-1:0]   step_index_next;
  logic [TIMER_WIDTH-1:0] step_elapsed_next;
  logic [TIMER_WIDTH-1:0] cooldown_count_next;
  logic [CfgWidth-1:0]    phase_time;
  logic                   start;

  always_comb begin
    running_next        = running;
    cooling_next        = cooling;
    relay_drive_next    = relay_drive;
    step_index_next     = step_index;
    step_elapsed_next   = step_elapsed;
    cooldown_count_next = cooldown_count;

    // Advance cooldown and release once the count is reached
    if (cooling) begin
      if (cooldown_count != '1) begin
        cooldown_count_next = cooldown_count + TIMER_WIDTH'(1);
      end
      if (CmpWidth'(cooldown_count_next) >= CmpWidth'(cfg.cooldown_ms)) begin
        cooling_next = 1'b0;
      end
    end

    if (running && (step_elapsed != '1)) begin
      step_elapsed_next = step_elapsed + TIMER_WIDTH'(1);
    end

    start = press && !running && !cooling_next;
    if (start) begin
      running_next      = 1'b1;
      step_index_next   = STEP_BEEP_1;
      step_elapsed_next = '0;
      relay_drive_next  = 1'b1;
    end

    unique case (step_index_next)
      STEP_BEEP_1, STEP_BEEP_2, STEP_BEEP_3: phase_time = cfg.short_beep_ms;
      STEP_GAP_1, STEP_GAP_2:                phase_time = cfg.beep_gap_ms;
      STEP_PATTERN_GAP:                      phase_time = cfg.pattern_gap_ms;
      default:                               phase_time = cfg.long_beep_ms;
    endcase

    if (running_next && (CmpWidth'(step_elapsed_next) >= CmpWidth'(phase_time))) begin
      if (step_index_next >= STEP_LONG_BEEP) begin
        relay_drive_next    = 1'b0;
        running_next        = 1'b0;
        step_index_next     = STEP_BEEP_1;
        step_elapsed_next   = '0;
        cooldown_count_next = '0;
        cooling_next        = (cfg.cooldown_ms != '0);
      end else begin
        step_index_next   = step_index_next + StepWidth'(1);
        step_elapsed_next = '0;
        relay_drive_next  = !step_index_next[0];
      end
    end

    result_next.relay_on        = relay_drive_next;
    result_next.pattern_step    = step_index_next;
    result_next.sequence_active = running_next;
    result_next.cooling_down    = cooling_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running        <= 1'b0;
      cooling        <= 1'b0;
      relay_drive    <= 1'b0;
      step_index     <= STEP_BEEP_1;
      step_elapsed   <= '0;
      cooldown_count <= '0;
    end else if (tick) begin
      running        <= running_next;
      cooling        <= cooling_next;
      relay_drive    <= relay_drive_next;
      step_index     <= step_index_next;
      step_elapsed   <= step_elapsed_next;
      cooldown_count <= cooldown_count_next;
    end
  end

endmodule

[hw/rtl/debounced_trigger_beep_sequencer.sv]
// An accepted request has its result loaded into the output register as it is taken.
// Throughput: one request per cycle; the debounce and phase counters update in the
// cycle of acceptance, and a new request is taken whenever the output slot empties.
// Reset (rst, synchronous): registers return to their defaults, the button reads
// released, the horn is off, no pattern or cooldown runs and the output is empty.
module debounced_trigger_beep_sequencer #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write port
  input  logic                            cfg_write,
  input  logic [dtbs_pkg::IndexWidth-1:0] cfg_index,
  input  logic [dtbs_pkg::CfgWidth-1:0]   cfg_data,
  // Input channel: one request per millisecond tick
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            button_level,
  // Output channel: one result per request
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            relay_on,
  output logic [dtbs_pkg::StepWidth-1:0]  pattern_step,
  output logic                            sequence_active,
  output logic                            cooling_down
);
  import dtbs_pkg::*;

  cfg_t    cfg;
  result_t result_next;
  result_t result;
  logic    tick;
  logic    press;

  // Take a request whenever the result slot is free or drains this cycle
  assign in_ready = !out_valid || out_ready;
  assign tick     = in_valid && in_ready;

  dtbs_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Debounce the raw level; flag a settled fall to pressed
  dtbs_debounce #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_debounce (
    .clk   (clk),
    .rst   (rst),
    .tick  (tick),
    .raw   (button_level),
    .cfg   (cfg),
    .press (press)
  );

  // Run the seven phase horn pattern and the cooldown after it
  dtbs_pattern #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_pattern (
    .clk         (clk),
    .rst         (rst),
    .tick        (tick),
    .press       (press),
    .cfg         (cfg),
    .result_next (result_next)
  );

  // Result register: load on acceptance, hold while the consumer stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tick) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      result <= result_next;
    end
  end

  assign relay_on        = result.relay_on;
  assign pattern_step    = result.pattern_step;
  assign sequence_active = result.sequence_active;
  assign cooling_down    = result.cooling_down;

`ifndef ASSERT_OFF
  a_relay_only_on_beep: assert property (@(posedge clk) disable iff (rst)
    out_valid && relay_on |-> sequence_active && !pattern_step[0])
    else $error("relay energised outside a beep phase");

  a_step_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sequence_active |-> pattern_step == STEP_BEEP_1)
    else $error("pattern step not zero while idle");

  a_no_run_while_cooling: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(sequence_active && cooling_down))
    else $error("pattern running during cooldown");

  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pattern_step <= STEP_LONG_BEEP)
    else $error("pattern step out of range");
`endif

endmodule
